// ----- src/lagp_pkg.sv -----
// Package for the angular gap placement block: CORDIC constants and types.
// No dependencies.
`default_nettype none
package lagp_pkg;
	localparam int DEFAULT_MAX_POINTS = 8;
	localparam int CORDIC_STEPS = 16;
	localparam logic [16:0] FULL_Q8 = 17'd92160;
	localparam logic signed [35:0] DEG90 = 36'sd5898240;
	localparam logic signed [35:0] DEG180 = 36'sd11796480;
	localparam logic signed [35:0] DEG270 = 36'sd17694720;
	localparam logic signed [35:0] DEG360 = 36'sd23592960;
	localparam logic [15:0] GAIN_INV = 16'd39797;

	typedef enum logic [1:0] {
		CFG_LIMIT = 2'd0,
		CFG_RADIUS = 2'd1
	} cfg_idx_t;

	function automatic logic signed [35:0] atan_lut(input logic [3:0] i);
		case (i)
			4'd0: atan_lut = 36'sd2949120;
			4'd1: atan_lut = 36'sd1740967;
			4'd2: atan_lut = 36'sd919879;
			4'd3: atan_lut = 36'sd466945;
			4'd4: atan_lut = 36'sd234379;
			4'd5: atan_lut = 36'sd117304;
			4'd6: atan_lut = 36'sd58666;
			4'd7: atan_lut = 36'sd29335;
			4'd8: atan_lut = 36'sd14668;
			4'd9: atan_lut = 36'sd7334;
			4'd10: atan_lut = 36'sd3667;
			4'd11: atan_lut = 36'sd1833;
			4'd12: atan_lut = 36'sd917;
			4'd13: atan_lut = 36'sd458;
			4'd14: atan_lut = 36'sd229;
			4'd15: atan_lut = 36'sd115;
			default: atan_lut = 36'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ----- src/largest_angular_gap_placement.sv -----
// Top level of the angular gap placement block: one shared CORDIC stage
// reused for point angles and for the final rotation. Uses lagp_pkg.
//
// A point item keeps the block busy for 16 CORDIC steps, one rounding step
// and an insert that moves one stored angle up per cycle while it is larger
// than the new one, before writing the new one. A point on an axis skips the
// 16 CORDIC steps. A full store drops the point after the rounding step. A
// last item then adds the gap scan over the stored angles, the 16 rotation
// steps and the output step, and an empty item goes straight to the output.
// The result is shown from the next cycle on until it is taken. in_stall is
// high while an item is at work or a result waits, so items are handled
// strictly one at a time.
`default_nettype none
module largest_angular_gap_placement #(
	parameter int MAX_POINTS = lagp_pkg::DEFAULT_MAX_POINTS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [14:0]        cfg_data,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire logic signed [15:0] point_x,
	input  wire logic signed [15:0] point_y,
	input  wire logic               set_empty,
	input  wire logic               last_point,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      logic signed [15:0] place_x,
	output      logic signed [15:0] place_y,
	output      logic               points_dropped
);
	import lagp_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 2);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_ATAN   = 10'b0000000010,
		S_ANG    = 10'b0000000100,
		S_SHIFT  = 10'b0000001000,
		S_SCAN0  = 10'b0000010000,
		S_SCAN   = 10'b0000100000,
		S_PICK   = 10'b0001000000,
		S_ROT    = 10'b0010000000,
		S_FIN    = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	state_t state_q;
	logic limit_q;
	logic [14:0] radius_q;
	logic [16:0] mem [MAX_POINTS];
	logic [CW-1:0] count_q;
	logic ovf_q, last_q;
	logic signed [35:0] x_q, y_q, z_q;
	logic [3:0] step_q;
	logic rot_q;
	logic [1:0] quad_q;
	logic [16:0] ang_q;
	logic [CW-1:0] ptr_q;
	logic [16:0] first_q, prev_q, best_q, best_base_q;
	logic [16:0] rd_q;
	logic rd_ok_q;

	// Shared CORDIC stage.
	logic signed [35:0] dx, dy, at;
	logic dir;
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign at = atan_lut(step_q);
	assign dir = rot_q ? (z_q >= 0) : (y_q > 0);

	assign in_stall = (state_q != S_IDLE);

	// Magnitudes of x and of the upward y, and the sign of the upward y.
	logic signed [35:0] ax, ay;
	logic yneg;
	assign ax = point_x[15] ? -36'(point_x) : 36'(point_x);
	assign ay = point_y[15] ? -36'(point_y) : 36'(point_y);
	assign yneg = !point_y[15] && (point_y != 16'sd0);

	logic signed [35:0] zang, tq, tr;
	logic [16:0] tr17;
	always_comb begin
		if (z_q < 0) zang = '0;
		else if (z_q > DEG90) zang = DEG90;
		else zang = z_q;
		case (quad_q)
			2'd0: tq = zang;
			2'd1: tq = DEG180 - zang;
			2'd2: tq = DEG180 + zang;
			default: tq = DEG360 - zang;
		endcase
		tr = (tq + 36'sd128) >>> 8;
		tr17 = (tr >= 36'(FULL_Q8)) ? 17'd0 : tr[16:0];
	end

	// Insert: the entry below the cursor moves up while it is larger.
	logic [IW-1:0] below_idx;
	logic shift_up;
	assign below_idx = IW'(ptr_q - CW'(1));
	assign shift_up = (ptr_q != '0) && (mem[below_idx] > ang_q);

	logic [16:0] nxt, gap;
	logic better;
	assign nxt = rd_ok_q ? rd_q : 17'(first_q + FULL_Q8);
	assign gap = nxt - prev_q;
	assign better = ({7'd0, gap} * 24'd100) > ({7'd0, best_q} * 24'd101);

	logic [17:0] cap, inc;
	logic signed [35:0] zr, zw, zc;
	logic [1:0] zq;
	always_comb begin
		cap = (limit_q && count_q == CW'(1)) ? 18'd61440 : 18'd92160;
		inc = ({1'b0, best_q} < cap) ? {1'b0, best_q} : cap;
		zr = (36'({best_base_q, 1'b0}) + 36'(inc)) <<< 7;
		zw = (zr >= DEG360) ? zr - DEG360 : zr;
		if (zw <= DEG90) begin zc = zw; zq = 2'd0; end
		else if (zw <= DEG180) begin zc = DEG180 - zw; zq = 2'd1; end
		else if (zw <= DEG270) begin zc = zw - DEG180; zq = 2'd2; end
		else begin zc = DEG360 - zw; zq = 2'd3; end
	end

	logic [30:0] rad_gain;
	assign rad_gain = 31'(radius_q) * 31'(GAIN_INV);

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = (v + 36'sd32768) >>> 16;
		if (r > 36'sd32767) sat16 = 16'sh7FFF;
		else if (r < -36'sd32768) sat16 = 16'sh8000;
		else sat16 = r[15:0];
	endfunction

	always_ff @(posedge clk) begin
		rd_q <= mem[ptr_q[IW-1:0]];
		if (state_q == S_SHIFT) begin
			if (shift_up) mem[ptr_q[IW-1:0]] <= mem[below_idx];
			else mem[ptr_q[IW-1:0]] <= ang_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= 1'b0;
			radius_q <= 15'd800;
			count_q <= '0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'({1'b0, cfg_index}))
					CFG_LIMIT: limit_q <= cfg_data[0];
					CFG_RADIUS: radius_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (in_valid) begin
					last_q <= last_point;
					if (set_empty) begin
						place_x <= {1'b0, radius_q};
						place_y <= '0;
						points_dropped <= 1'b0;
						count_q <= '0;
						ovf_q <= 1'b0;
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end else begin
						x_q <= ax <<< 8;
						y_q <= ay <<< 8;
						step_q <= '0;
						rot_q <= 1'b0;
						quad_q <= {yneg, point_x[15] ^ yneg};
						if (ay == 0) begin
							z_q <= '0; state_q <= S_ANG;
						end else if (ax == 0) begin
							z_q <= DEG90; state_q <= S_ANG;
						end else begin
							z_q <= '0; state_q <= S_ATAN;
						end
					end
				end
				S_ATAN, S_ROT: begin
					if (dir) begin
						x_q <= rot_q ? x_q - dx : x_q + dx;
						y_q <= rot_q ? y_q + dy : y_q - dy;
						z_q <= rot_q ? z_q - at : z_q + at;
					end else begin
						x_q <= rot_q ? x_q + dx : x_q - dx;
						y_q <= rot_q ? y_q - dy : y_q + dy;
						z_q <= rot_q ? z_q + at : z_q - at;
					end
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15) state_q <= rot_q ? S_FIN : S_ANG;
				end
				S_ANG: begin
					ang_q <= tr17;
					ptr_q <= count_q;
					if (count_q >= CW'(MAX_POINTS)) begin
						ovf_q <= 1'b1;
						state_q <= last_q ? S_SCAN0 : S_IDLE;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (shift_up) begin
						ptr_q <= ptr_q - CW'(1);
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? S_SCAN0 : S_IDLE;
					end
				end
				S_SCAN0: begin
					state_q <= S_SCAN;
					rd_ok_q <= 1'b0;
					best_base_q <= mem[IW'(0)];
					first_q <= mem[IW'(0)];
					prev_q <= mem[IW'(0)];
					best_q <= ((count_q > CW'(1)) ? mem[IW'(1)] : 17'(mem[IW'(0)] + FULL_Q8))
						- mem[IW'(0)];
					ptr_q <= CW'(1);
				end
				S_SCAN: begin
					rd_ok_q <= (ptr_q < count_q);
					if (ptr_q >= CW'(2) || ptr_q == CW'(1) && rd_ok_q) begin
						if (better) begin best_q <= gap; best_base_q <= prev_q; end
						prev_q <= nxt;
					end
					if (rd_ok_q || ptr_q == CW'(1)) ptr_q <= ptr_q + CW'(1);
					if (!rd_ok_q && ptr_q != CW'(1)) state_q <= S_PICK;
				end
				S_PICK: begin
					x_q <= 36'(rad_gain);
					y_q <= '0;
					z_q <= zc;
					quad_q <= zq;
					step_q <= '0;
					rot_q <= 1'b1;
					state_q <= S_ROT;
				end
				S_FIN: begin
					place_x <= sat16(quad_q[0] ^ quad_q[1] ? -x_q : x_q);
					place_y <= sat16(quad_q[1] ? y_q : -y_q);
					points_dropped <= ovf_q;
					count_q <= '0;
					ovf_q <= 1'b0;
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> state_q == S_OUT)
		else $error("result shown outside output state");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_POINTS))
		else $error("angle count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(place_x))
		else $error("stalled result changed");
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for largest_angular_gap_placement: random point sets checked against a
// bit-exact fixed-point predictor held in a small scoreboard class. Uses lagp_pkg.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lagp_pkg::*;

	class gap_scoreboard;
		typedef struct {
			logic signed [15:0] px;
			logic signed [15:0] py;
			logic               dropped;
		} placement_t;

		bit [16:0]    angles[8];
		int unsigned  count;
		bit           ovf;
		bit           lim120;
		bit [14:0]    radius = 15'd800;
		placement_t   pending_q[$];
		int           errors;

		function longint fshift(longint v, int s);
			return v >>> s;
		endfunction

		function longint quad_atan(longint ax, longint ay);
			longint x, y, z, dx, dy;
			x = ax * 256;
			y = ay * 256;
			z = 0;
			if (ay == 0) return 0;
			if (ax == 0) return longint'(DEG90);
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = fshift(y, i);
				dy = fshift(x, i);
				if (y > 0) begin
					x += dx; y -= dy; z += longint'(atan_lut(4'(i)));
				end else begin
					x -= dx; y += dy; z -= longint'(atan_lut(4'(i)));
				end
			end
			if (z < 0) z = 0;
			if (z > longint'(DEG90)) z = longint'(DEG90);
			return z;
		endfunction

		function bit [16:0] angle_of(logic signed [15:0] px, logic signed [15:0] py);
			longint xv, yv, q, t, r;
			xv = px;
			yv = -longint'(py);
			q = quad_atan(xv < 0 ? -xv : xv, yv < 0 ? -yv : yv);
			if (xv >= 0 && yv >= 0) t = q;
			else if (xv < 0 && yv >= 0) t = longint'(DEG180) - q;
			else if (xv < 0) t = longint'(DEG180) + q;
			else t = longint'(DEG360) - q;
			r = (t + 128) >>> 8;
			return (r >= longint'(FULL_Q8)) ? 17'd0 : 17'(r);
		endfunction

		function void rotate(longint z, output longint cx, output longint sy);
			longint x, y, dx, dy;
			x = longint'(radius) * longint'(GAIN_INV);
			y = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = fshift(y, i);
				dy = fshift(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(atan_lut(4'(i)));
				end else begin
					x += dx; y -= dy; z += longint'(atan_lut(4'(i)));
				end
			end
			cx = x;
			sy = y;
		endfunction

		function logic signed [15:0] round_sat(longint v);
			v = (v + 32768) >>> 16;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return 16'(v);
		endfunction

		function void store_angle(bit [16:0] a);
			int unsigned p;
			if (count >= 8) begin
				ovf = 1;
				return;
			end
			p = 0;
			while (p < count && angles[p] <= a) p++;
			for (int unsigned k = count; k > p; k--) angles[k] = angles[k-1];
			angles[p] = a;
			count++;
		endfunction

		function placement_t widest_gap_point();
			placement_t r;
			longint best, d, nxt, cap, inc, z, cx, sy, c, s;
			int unsigned best_i;
			best_i = 0;
			best = (count > 1 ? longint'(angles[1]) : longint'(angles[0]) + longint'(FULL_Q8))
				- longint'(angles[0]);
			for (int unsigned i = 0; i < count; i++) begin
				nxt = (i + 1 < count) ? longint'(angles[i+1])
					: longint'(angles[0]) + longint'(FULL_Q8);
				d = nxt - longint'(angles[i]);
				if (d * 100 > best * 101) begin
					best_i = i;
					best = d;
				end
			end
			// A gap in Q9.8 reads directly as the half-gap in Q9.9.
			cap = (lim120 && count == 1) ? 120 * 512 : 180 * 512;
			inc = best < cap ? best : cap;
			z = (longint'(angles[best_i]) * 2 + inc) * 128;
			while (z >= longint'(DEG360)) z -= longint'(DEG360);
			if (z <= longint'(DEG90)) begin
				rotate(z, cx, sy); c = cx; s = sy;
			end else if (z <= longint'(DEG180)) begin
				rotate(longint'(DEG180) - z, cx, sy); c = -cx; s = sy;
			end else if (z <= longint'(DEG270)) begin
				rotate(z - longint'(DEG180), cx, sy); c = -cx; s = -sy;
			end else begin
				rotate(longint'(DEG360) - z, cx, sy); c = cx; s = -sy;
			end
			r.px = round_sat(c);
			r.py = round_sat(-s);
			r.dropped = ovf;
			return r;
		endfunction

		function void note_input(logic signed [15:0] px, logic signed [15:0] py,
				logic emp, logic last);
			placement_t r;
			if (emp) begin
				r.px = {1'b0, radius};
				r.py = 16'sd0;
				r.dropped = 1'b0;
				pending_q = {pending_q, r};
				count = 0;
				ovf = 0;
				return;
			end
			store_angle(angle_of(px, py));
			if (!last) return;
			r = widest_gap_point();
			pending_q = {pending_q, r};
			count = 0;
			ovf = 0;
		endfunction

		function void check_result(logic signed [15:0] px, logic signed [15:0] py, logic d);
			placement_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d dropped=%0b", $time, px, py, d);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (px !== e.px) begin
				$display("%0t: place_x expected %0d actual %0d", $time, e.px, px);
				errors++;
			end
			if (py !== e.py) begin
				$display("%0t: place_y expected %0d actual %0d", $time, e.py, py);
				errors++;
			end
			if (d !== e.dropped) begin
				$display("%0t: points_dropped expected %0b actual %0b", $time, e.dropped, d);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [0:0]         cfg_index = '0;
	logic [14:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] point_x = '0;
	logic signed [15:0] point_y = '0;
	logic               set_empty = 1'b0;
	logic               last_point = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] place_x;
	logic signed [15:0] place_y;
	logic               points_dropped;

	gap_scoreboard sb = new();
	bit calm;
	int idle_cycles;

	largest_angular_gap_placement i_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .point_x, .point_y, .set_empty, .last_point,
		.out_valid, .out_stall, .place_x, .place_y, .points_dropped
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Leaves the write enable high; the caller drops it after the last write.
	task automatic write_reg(cfg_idx_t idx, logic [14:0] val);
		cfg_we <= 1'b1;
		cfg_index <= 1'(idx);
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_LIMIT) sb.lim120 = val[0];
		else sb.radius = val;
	endtask

	task automatic set_phase(bit lim, logic [14:0] rad);
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		write_reg(CFG_LIMIT, {14'd0, lim});
		write_reg(CFG_RADIUS, rad);
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(logic signed [15:0] px, logic signed [15:0] py,
			logic emp, logic last);
		if (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		set_empty <= emp;
		last_point <= last;
		do @(posedge clk); while (in_stall);
		sb.note_input(px, py, emp, last);
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(9))
			0: return 16'sd0;
			1: return 16'sh7fff;
			2: return 16'sh8000;
			3, 4: return 16'($signed($urandom_range(0, 200)) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_sets(int items);
		int sent, n;
		sent = 0;
		while (sent < items) begin
			calm = (sent >= items / 3 && sent < items / 2);
			if ($urandom_range(19) == 0) begin
				send_item(16'($urandom), 16'($urandom), 1'b1, 1'($urandom));
				sent++;
				continue;
			end
			n = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 11);
			for (int k = 0; k < n; k++) begin
				// Now and then an empty item breaks into the set and discards it.
				if ($urandom_range(49) == 0)
					send_item(rand_coord(), rand_coord(), 1'b1, 1'b0);
				else
					send_item(rand_coord(), rand_coord(), 1'b0, k == n - 1);
				sent++;
			end
		end
		calm = 0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_phase(1'b0, 15'd800);
		// Directed: empty set, single points on axes and corners, origin, overflow.
		send_item(16'sd5, 16'sd5, 1'b1, 1'b0);
		send_item(16'sd0, 16'sd0, 1'b0, 1'b1);
		send_item(16'sh7fff, 16'sd0, 1'b0, 1'b1);
		send_item(16'sh8000, 16'sh8000, 1'b0, 1'b1);
		send_item(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
		send_item(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
		send_item(16'sd0, 16'sh8000, 1'b0, 1'b0);
		send_item(16'sd0, 16'sh7fff, 1'b0, 1'b1);
		for (int k = 0; k < 10; k++)
			send_item(16'(k * 300 - 1500), 16'(k * 97 - 400), 1'b0, k == 9);
		send_item(16'sd100, 16'sd0, 1'b0, 1'b0);
		send_item(16'sd0, 16'sd0, 1'b1, 1'b1);
		set_phase(1'b1, 15'd32767);
		send_item(16'sd16, 16'sd16, 1'b0, 1'b1);
		send_item(16'sh8000, 16'sd0, 1'b0, 1'b1);
		send_item(16'sd0, 16'sd0, 1'b1, 1'b0);
		random_sets(200);
		set_phase(1'b1, 15'd0);
		random_sets(200);
		set_phase(1'b0, 15'd1);
		random_sets(200);
		set_phase(1'b0, 15'd32767);
		random_sets(220);
		set_phase(1'($urandom), 15'($urandom));
		random_sets(200);
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin : receiver
		int cyc;
		bit held;
		cyc = 0;
		held = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (out_valid && !out_stall) sb.check_result(place_x, place_y, points_dropped);
			if (!held && cyc >= 6000 && in_valid) begin
				// Long hold-off so that the block backs up and stalls its input.
				held = 1;
				out_stall <= 1'b1;
				repeat (500) @(posedge clk);
				cyc++;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 37);
			end
		end
	end

	initial begin : watchdog
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= 5000) begin
				$display("Verification failed");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire
